// ===== design/rdp2p_pkg.sv =====
// rdp2p_pkg: types and constants shared by the peak-to-peak ring detector
// no dependencies; used by every module in the design folder
package rdp2p_pkg;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_EVAL_PERIOD   = 2'd0;
    localparam cfg_index_t REG_AMP_THRESHOLD = 2'd1;
    localparam cfg_index_t REG_SILENCE_TMO   = 2'd2;
    localparam cfg_index_t REG_COUNT_THRESH  = 2'd3;

    localparam logic [15:0] EVAL_PERIOD_RST   = 16'd100;
    localparam logic [9:0]  AMP_THRESHOLD_RST = 10'd205;
    localparam logic [15:0] SILENCE_TMO_RST   = 16'd2000;
    localparam logic [7:0]  COUNT_THRESH_RST  = 8'd5;

    localparam logic [9:0] ADC_FULL  = 10'd1023;
    localparam logic [8:0] COUNT_MAX = 9'd511;

    typedef struct packed {
        logic [15:0] eval_period_ms;
        logic [9:0]  amplitude_threshold;
        logic [15:0] silence_timeout_ms;
        logic [7:0]  count_threshold;
    } cfg_t;

    typedef struct packed {
        logic [9:0]  peak_max;
        logic [9:0]  peak_min;
        logic [31:0] last_eval_time;
        logic [31:0] last_loud_time;
        logic [8:0]  loud_count;
    } state_t;

    typedef struct packed {
        logic ringing;
        logic evaluated;
    } eval_flags_t;

endpackage

// ===== design/rdp2p_cfg.sv =====
// rdp2p_cfg: configuration register bank of the ring detector
// depends on rdp2p_pkg
module rdp2p_cfg
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  rdp2p_pkg::cfg_index_t cfg_index,
    input  logic [15:0]           cfg_data,
    output rdp2p_pkg::cfg_t       cfg
);

    rdp2p_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eval_period_ms      <= rdp2p_pkg::EVAL_PERIOD_RST;
            cfg_reg.amplitude_threshold <= rdp2p_pkg::AMP_THRESHOLD_RST;
            cfg_reg.silence_timeout_ms  <= rdp2p_pkg::SILENCE_TMO_RST;
            cfg_reg.count_threshold     <= rdp2p_pkg::COUNT_THRESH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rdp2p_pkg::REG_EVAL_PERIOD:   cfg_reg.eval_period_ms      <= cfg_data;
                rdp2p_pkg::REG_AMP_THRESHOLD: cfg_reg.amplitude_threshold <= cfg_data[9:0];
                rdp2p_pkg::REG_SILENCE_TMO:   cfg_reg.silence_timeout_ms  <= cfg_data;
                rdp2p_pkg::REG_COUNT_THRESH:  cfg_reg.count_threshold     <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/rdp2p_eval.sv =====
// rdp2p_eval: combinational update of tracker, timers and loud-window count
// depends on rdp2p_pkg
module rdp2p_eval
(
    input  rdp2p_pkg::cfg_t        cfg,
    input  rdp2p_pkg::state_t      state,
    input  logic                   req_type,
    input  logic [9:0]             adc_sample,
    input  logic [31:0]            now_ms,
    output rdp2p_pkg::state_t      state_next,
    output rdp2p_pkg::eval_flags_t flags
);

    logic [9:0]  max_upd;
    logic [9:0]  min_upd;
    logic [31:0] since_eval;
    logic [31:0] since_loud;
    logic        due;
    logic [9:0]  spread;
    logic        loud;
    logic        quiet_expired;
    logic [8:0]  count_win;

    always_comb
    begin
        max_upd       = (adc_sample > state.peak_max) ? adc_sample : state.peak_max;
        min_upd       = (adc_sample < state.peak_min) ? adc_sample : state.peak_min;
        since_eval    = now_ms - state.last_eval_time;
        since_loud    = now_ms - state.last_loud_time;
        due           = since_eval >= {16'd0, cfg.eval_period_ms};
        spread        = (min_upd > max_upd) ? 10'd0 : (max_upd - min_upd);
        loud          = spread > cfg.amplitude_threshold;
        quiet_expired = since_loud > {16'd0, cfg.silence_timeout_ms};

        // count after the window verdict, before the ringing test
        if (loud)
            count_win = (state.loud_count < rdp2p_pkg::COUNT_MAX)
                        ? state.loud_count + 9'd1 : state.loud_count;
        else if (quiet_expired)
            count_win = 9'd0;
        else
            count_win = state.loud_count;

        state_next    = state;
        flags.ringing = 1'b0;
        flags.evaluated = 1'b0;

        if (req_type)
        begin
            // dtmf event only clears the count
            state_next.loud_count = 9'd0;
        end
        else if (due)
        begin
            flags.evaluated           = 1'b1;
            state_next.last_eval_time = now_ms;
            state_next.peak_max       = 10'd0;
            state_next.peak_min       = rdp2p_pkg::ADC_FULL;
            if (loud)
                state_next.last_loud_time = now_ms;
            if (count_win > {1'b0, cfg.count_threshold})
            begin
                state_next.loud_count = 9'd0;
                flags.ringing         = 1'b1;
            end
            else
                state_next.loud_count = count_win;
        end
        else
        begin
            state_next.peak_max = max_upd;
            state_next.peak_min = min_upd;
        end
    end

endmodule

// ===== design/ring_detector_peak_to_peak_unit.sv =====
// ring_detector_peak_to_peak_unit: top level of the peak-to-peak ring detector
// depends on rdp2p_pkg, rdp2p_cfg and rdp2p_eval
//
// path: an accepted word waits in the input register, and its result is then
// registered in the result register, from which it shows on the output
// throughput: one word per cycle unless the output stalls; the tracker, timer
// compares and count update all sit between the input register and the result register
// reset: configuration returns to its defaults, tracker, timers and count clear
module ring_detector_peak_to_peak_unit
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write port
    input  logic                  cfg_we,
    input  rdp2p_pkg::cfg_index_t cfg_index,
    input  logic [15:0]           cfg_data,

    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [9:0]            adc_sample,
    input  logic [31:0]           now_ms,

    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  ringing,
    output logic [8:0]            ring_count
);

    rdp2p_pkg::cfg_t        cfg;
    rdp2p_pkg::state_t      state_reg;
    rdp2p_pkg::state_t      state_next;
    rdp2p_pkg::eval_flags_t flags;

    // input register stage
    logic        s1_valid_reg;
    logic        s1_req_reg;
    logic [9:0]  s1_sample_reg;
    logic [31:0] s1_now_reg;

    // result register stage
    logic        out_valid_reg;
    logic        ringing_reg;
    logic [8:0]  ring_count_reg;

    logic        advance;
    logic        s1_load;

    // result register frees up when empty or being taken this cycle
    assign advance  = !out_valid_reg || !out_stall;
    // input register takes a word when empty or handing its word on
    assign s1_load  = !s1_valid_reg || advance;
    assign in_stall = !s1_load;

    rdp2p_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // next state is computed from the word sitting in the input register
    rdp2p_eval u_eval
    (
        .cfg        (cfg),
        .state      (state_reg),
        .req_type   (s1_req_reg),
        .adc_sample (s1_sample_reg),
        .now_ms     (s1_now_reg),
        .state_next (state_next),
        .flags      (flags)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= in_valid;
    end

    // input register payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_req_reg    <= req_type;
            s1_sample_reg <= adc_sample;
            s1_now_reg    <= now_ms;
        end
    end

    // detector state commits when its word moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.peak_max       <= 10'd0;
            state_reg.peak_min       <= rdp2p_pkg::ADC_FULL;
            state_reg.last_eval_time <= 32'd0;
            state_reg.last_loud_time <= 32'd0;
            state_reg.loud_count     <= 9'd0;
        end
        else if (advance && s1_valid_reg)
            state_reg <= state_next;
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            ringing_reg    <= flags.ringing;
            ring_count_reg <= state_next.loud_count;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ringing    = ringing_reg;
    assign ring_count = ring_count_reg;

    // input side only backs up when both stages hold words and the output stalls
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stall without a full pipeline");

    // a dtmf word leaves the count clear
    a_dtmf_clear : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_valid_reg && s1_req_reg) |=> (state_reg.loud_count == 9'd0))
        else $error("dtmf word did not clear the count");

    // every evaluation empties the tracker
    a_tracker_clear : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_valid_reg && flags.evaluated)
        |=> (state_reg.peak_max == 10'd0 && state_reg.peak_min == rdp2p_pkg::ADC_FULL))
        else $error("tracker not cleared after evaluation");

    // a ringing report always comes with a cleared count
    a_ring_count : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ringing_reg) |-> (ring_count_reg == 9'd0))
        else $error("ringing reported with a non-zero count");

endmodule
